### sv/sprite_quad_batcher_top_assert.svh
// ----------------------------------------------------------------------------
// Sprite quad batcher assertion macros
// Shared property forms for the batcher's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SPRITE_QUAD_BATCHER_TOP_ASSERT_SVH
`define SPRITE_QUAD_BATCHER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SQB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define SQB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/sqb_pkg.sv
// ----------------------------------------------------------------------------
// Sprite quad batcher package
// Item layouts, command/status bundles, mode codes and the sine ROM builder.
// ----------------------------------------------------------------------------
package sqb_pkg;

   // command kinds carried on req_tuser
   localparam logic [1:0] MODE_PLAIN    = 2'd0;
   localparam logic [1:0] MODE_TEXTURED = 2'd1;
   localparam logic [1:0] MODE_FLUSH    = 2'd2;
   localparam logic [1:0] MODE_NONE     = 2'd3;

   localparam int unsigned SINE_TABLE_DEPTH = 1024;
   localparam int unsigned ROM_AW = $clog2(SINE_TABLE_DEPTH + 1);
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [15:0] ONE_Q15 = 16'd32768;
   localparam int unsigned REQ_DATA_W = 312;
   localparam int unsigned RSP_DATA_W = 200;

   // Taylor divisors (2n)(2n+1)
   localparam logic [63:0] TAYLOR_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                64'd110, 64'd156, 64'd210, 64'd272};

   typedef logic [15:0] rom_type [0:SINE_TABLE_DEPTH];

   // input item, first field lowest
   typedef struct packed {
      logic [5:0]         pad;
      logic [63:0]        tex_rect;
      logic [31:0]        texture_id;
      logic [31:0]        outline_color;
      logic [15:0]        outline_width;
      logic [31:0]        color;
      logic [11:0]        angle;
      logic [22:0]        height;
      logic [22:0]        width;
      logic signed [23:0] pos_z;
      logic signed [23:0] pos_y;
      logic signed [23:0] pos_x;
   } req_data_type;

   // result item, first field lowest
   typedef struct packed {
      logic               pad;
      logic [10:0]        flushed_quads;
      logic [31:0]        vert_outline_color;
      logic [15:0]        vert_outline_width;
      logic [3:0]         slot_index;
      logic [15:0]        tex_v;
      logic [15:0]        tex_u;
      logic [31:0]        vert_color;
      logic signed [23:0] vert_z;
      logic signed [23:0] vert_y;
      logic signed [23:0] vert_x;
   } rsp_data_type;

   typedef struct packed {
      logic       load_in;
      logic       batch;
      logic       mul;
      logic       emit;
      logic       flush;
      logic [1:0] vidx;
   } cmd_type;

   typedef struct packed {
      logic       out_free;
   } sts_type;

   // one quarter-wave entry, Q1.15
   function automatic logic [15:0] sine_entry(input int unsigned k);
      logic [63:0] th;
      logic [63:0] th2;
      logic [63:0] sum;
      logic [63:0] term;
      th = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
      th2 = (th * th) >> 30;
      sum = th;
      term = th;
      for (int n = 1; n <= 8; n++) begin
         term = ((term * th2) >> 30) / TAYLOR_DIV[n];
         if (n % 2 == 1) sum = (sum >= term) ? sum - term : 64'd0;
         else sum = sum + term;
      end
      sum = (sum + 64'd16384) >> 15;
      if (sum > 64'(ONE_Q15)) sum = 64'(ONE_Q15);
      return sum[15:0];
   endfunction

   function automatic rom_type build_sine_rom();
      rom_type r;
      for (int unsigned k = 0; k <= SINE_TABLE_DEPTH; k++) r[k] = sine_entry(k);
      return r;
   endfunction

endpackage

### sv/sqb_ctrl.sv
// ----------------------------------------------------------------------------
// Sprite quad batcher controller
// Sequences accept, ROM read, multiply, vertex emits or flush of one command.
// ----------------------------------------------------------------------------
`include "sprite_quad_batcher_top_assert.svh"

module sqb_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [1:0]      req_tuser,
   input  sqb_pkg::sts_type sts,
   output sqb_pkg::cmd_type cmd
);
   import sqb_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ROM   = 5'b00010,
      ST_MUL   = 5'b00100,
      ST_EMIT  = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] vcnt_ff, vcnt_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      vcnt_in = vcnt_ff;
      cmd = '0;
      cmd.vidx = vcnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_in = 1'b1;
               priority if (req_tuser == MODE_NONE) state_in = ST_IDLE;
               else if (req_tuser == MODE_FLUSH) state_in = ST_FLUSH;
               else state_in = ST_ROM;
            end
         end
         ST_ROM: begin
            cmd.batch = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            vcnt_in = 2'd0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               vcnt_in = vcnt_ff + 2'd1;
               if (vcnt_ff == 2'd3) state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vcnt_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         vcnt_ff <= vcnt_in;
      end
   end

   `SQB_ASSERT_NEXT(a_fourth_vertex_ends, clock, reset, cmd.emit && vcnt_ff == 2'd3, state_ff == ST_IDLE, "quad did not end after fourth vertex")
   `SQB_ASSERT_NOW(a_emit_needs_room, clock, reset, cmd.emit || cmd.flush, sts.out_free, "result issued into a full output register")
   `SQB_ASSERT_NEXT(a_quad_starts, clock, reset, accept && (req_tuser == MODE_PLAIN || req_tuser == MODE_TEXTURED), state_ff == ST_ROM, "quad command did not start")

endmodule

### sv/sqb_datapath.sv
// ----------------------------------------------------------------------------
// Sprite quad batcher datapath
// Holds the command, batch and slot state, sine ROM, multipliers and the
// output register.
// ----------------------------------------------------------------------------
module sqb_datapath #(
   parameter int MAX_QUADS  = 1024,
   parameter int SLOT_COUNT = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [sqb_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [1:0]                      req_tuser,
   input  logic                            csr_valid,
   input  logic [31:0]                     csr_data,
   input  sqb_pkg::cmd_type                cmd,
   output sqb_pkg::sts_type                sts,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sqb_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast
);
   import sqb_pkg::*;

   localparam int COUNT_W = $clog2(MAX_QUADS + 1);
   localparam int NFS_W   = $clog2(SLOT_COUNT + 1);
   localparam int SLOT_W  = $clog2(SLOT_COUNT);
   localparam rom_type SINE_ROM = build_sine_rom();

   req_data_type        in_ff;
   logic [1:0]          mode_ff;
   logic [31:0]         white_ff;
   logic [COUNT_W-1:0]  count_ff, count_in, count_eff;
   logic [NFS_W-1:0]    nfs_ff, nfs_in, nfs_eff;
   logic [31:0]         slot_tab_ff [1:SLOT_COUNT-1];
   logic [SLOT_W-1:0]   slot_ff, slot_in, found_idx;
   logic [10:0]         flushed_ff, count_sat;
   logic                tex, close, found, new_alloc;

   // command capture
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         in_ff <= req_data_type'(req_tdata);
         mode_ff <= req_tuser;
      end
   end

   assign tex = (mode_ff == MODE_TEXTURED);
   assign count_sat = (32'(count_ff) > 32'd2047) ? 11'd2047 : 11'(count_ff);

   // batch close and slot lookup
   always_comb begin
      close = (32'(count_ff) >= 32'(MAX_QUADS)) ||
              (tex && (32'(nfs_ff) >= 32'(SLOT_COUNT)));
      count_eff = close ? '0 : count_ff;
      nfs_eff = close ? NFS_W'(1) : nfs_ff;
      found = 1'b0;
      found_idx = '0;
      for (int i = SLOT_COUNT - 1; i >= 1; i--) begin
         if ((32'(i) < 32'(nfs_eff)) && (slot_tab_ff[i] == in_ff.texture_id)) begin
            found = 1'b1;
            found_idx = SLOT_W'(i);
         end
      end
      new_alloc = tex && !found && (in_ff.texture_id != white_ff) &&
                  (32'(nfs_eff) < 32'(SLOT_COUNT));
      priority if (!tex) slot_in = '0;
      else if (found) slot_in = found_idx;
      else if (new_alloc) slot_in = SLOT_W'(nfs_eff);
      else slot_in = '0;
      count_in = count_eff + COUNT_W'(1);
      nfs_in = new_alloc ? nfs_eff + NFS_W'(1) : nfs_eff;
   end

   // batch state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         nfs_ff <= NFS_W'(1);
         white_ff <= 32'd1;
      end else begin
         if (csr_valid) white_ff <= csr_data;
         if (cmd.batch) begin
            count_ff <= count_in;
            nfs_ff <= nfs_in;
         end else if (cmd.flush) begin
            count_ff <= '0;
            nfs_ff <= NFS_W'(1);
         end
      end
   end

   // slot table, valid below the free pointer
   always_ff @(posedge clock) begin
      if (cmd.batch && new_alloc) slot_tab_ff[SLOT_W'(nfs_eff)] <= in_ff.texture_id;
      if (cmd.batch) begin
         slot_ff <= slot_in;
         flushed_ff <= close ? count_sat : 11'd0;
      end
   end

   // sine ROM, two registered reads
   logic [11:0]       ang_c;
   logic [ROM_AW-1:0] idx_s, idx_c;
   logic [15:0]       rom_s_ff, rom_c_ff;
   logic              neg_s_ff, neg_c_ff;

   function automatic logic [ROM_AW-1:0] rom_index(input logic [11:0] a);
      logic [10:0] rr;
      logic [31:0] scaled;
      rr = a[10] ? (11'd1024 - {1'b0, a[9:0]}) : {1'b0, a[9:0]};
      scaled = (32'(rr) * 32'(SINE_TABLE_DEPTH)) >> 10;
      return scaled[ROM_AW-1:0];
   endfunction

   assign ang_c = in_ff.angle + 12'd1024;
   assign idx_s = rom_index(in_ff.angle);
   assign idx_c = rom_index(ang_c);

   always_ff @(posedge clock) begin
      if (cmd.batch) begin
         rom_s_ff <= SINE_ROM[idx_s];
         rom_c_ff <= SINE_ROM[idx_c];
         neg_s_ff <= in_ff.angle[11];
         neg_c_ff <= ang_c[11];
      end
   end

   // size times sine/cosine
   logic signed [16:0] sin_v, cos_v;
   logic signed [40:0] wc_ff, ws_ff, hc_ff, hs_ff;

   assign sin_v = neg_s_ff ? -$signed({1'b0, rom_s_ff}) : $signed({1'b0, rom_s_ff});
   assign cos_v = neg_c_ff ? -$signed({1'b0, rom_c_ff}) : $signed({1'b0, rom_c_ff});

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         wc_ff <= 41'($signed({1'b0, in_ff.width}) * cos_v);
         ws_ff <= 41'($signed({1'b0, in_ff.width}) * sin_v);
         hc_ff <= 41'($signed({1'b0, in_ff.height}) * cos_v);
         hs_ff <= 41'($signed({1'b0, in_ff.height}) * sin_v);
      end
   end

   // corner offset, rounding and saturation
   logic               xs, ys;
   logic signed [42:0] ox, oy;
   logic signed [27:0] vx, vy;
   logic signed [23:0] sat_x, sat_y;
   logic [15:0]        u0, v0, u1, v1;

   function automatic logic [15:0] sat_uv(input logic [15:0] v);
      return (v > ONE_Q15) ? ONE_Q15 : v;
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
      if (v > 28'sd8388607) return 24'sh7FFFFF;
      if (v < -28'sd8388608) return 24'sh800000;
      return v[23:0];
   endfunction

   always_comb begin
      xs = (cmd.vidx == 2'd1) || (cmd.vidx == 2'd2);
      ys = cmd.vidx[1];
      ox = (xs ? 43'(wc_ff) : -43'(wc_ff)) - (ys ? 43'(hs_ff) : -43'(hs_ff));
      oy = (xs ? 43'(ws_ff) : -43'(ws_ff)) + (ys ? 43'(hc_ff) : -43'(hc_ff));
      vx = 28'(in_ff.pos_x) + 28'((ox + 43'sd32768) >>> 16);
      vy = 28'(in_ff.pos_y) + 28'((oy + 43'sd32768) >>> 16);
      sat_x = sat24(vx);
      sat_y = sat24(vy);
      if (tex) begin
         u0 = sat_uv(in_ff.tex_rect[15:0]);
         v0 = sat_uv(in_ff.tex_rect[31:16]);
         u1 = sat_uv(in_ff.tex_rect[47:32]);
         v1 = sat_uv(in_ff.tex_rect[63:48]);
      end else begin
         u0 = 16'd0;
         v0 = 16'd0;
         u1 = ONE_Q15;
         v1 = ONE_Q15;
      end
   end

   // output register
   rsp_data_type     out_ff;
   rsp_data_type     flush_item;
   logic             valid_ff, last_ff;
   logic [4:0]       slot5;

   assign slot5 = 5'(slot_ff);
   assign sts.out_free = !valid_ff || rsp_tready;

   // end-of-scene item: only the quad count is set
   always_comb begin
      flush_item = '0;
      flush_item.flushed_quads = count_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit || cmd.flush) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.flush) begin
         out_ff <= flush_item;
         last_ff <= 1'b1;
      end else if (cmd.emit) begin
         out_ff.pad <= 1'b0;
         out_ff.vert_x <= sat_x;
         out_ff.vert_y <= sat_y;
         out_ff.vert_z <= in_ff.pos_z;
         out_ff.vert_color <= in_ff.color;
         out_ff.tex_u <= xs ? u1 : u0;
         out_ff.tex_v <= ys ? v1 : v0;
         out_ff.slot_index <= slot5[3:0];
         out_ff.vert_outline_width <= tex ? 16'd0 : in_ff.outline_width;
         out_ff.vert_outline_color <= tex ? 32'd0 : in_ff.outline_color;
         out_ff.flushed_quads <= (cmd.vidx == 2'd0) ? flushed_ff : 11'd0;
         last_ff <= (cmd.vidx == 2'd3);
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = RSP_DATA_W'(out_ff);
   assign rsp_tlast = last_ff;

endmodule

### sv/sprite_quad_batcher_top.sv
// ----------------------------------------------------------------------------
// Sprite quad batcher
// Expands sprite commands into rotated, textured vertex streams in batches.
// ----------------------------------------------------------------------------
// A quad command steps through capture, slot lookup with sine/cosine ROM
// read and multiply, then issues one vertex per cycle while the output is
// taken; an end-of-scene command is captured and then issues its result,
// and an unused mode is only accepted. One command is in work at a time;
// the ROM read and the four size-by-sine/cosine multiplies have a state each.
// A new batch begins on end of scene, at MAX_QUADS quads, or when a textured
// quad finds every texture slot taken.
// ----------------------------------------------------------------------------
`include "sprite_quad_batcher_top_assert.svh"

module sprite_quad_batcher_top #(
   parameter int MAX_QUADS  = 1024,
   parameter int SLOT_COUNT = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   // config: white_texture_id
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [31:0]                    csr_data,
   // tdata: pos_x, pos_y, pos_z, width, height, angle, color, outline_width,
   //        outline_color, texture_id, tex_rect, zero pad
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [sqb_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: mode
   input  logic [1:0]                     req_tuser,
   // tdata: vert_x, vert_y, vert_z, vert_color, tex_u, tex_v, slot_index,
   //        vert_outline_width, vert_outline_color, flushed_quads, zero pad
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sqb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);
   import sqb_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   sqb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   sqb_datapath #(
      .MAX_QUADS  (MAX_QUADS),
      .SLOT_COUNT (SLOT_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `SQB_ASSERT_NOW(a_busy_while_output, clock, reset, cmd.emit, !req_tready, "vertex issued while accepting a command")
   `SQB_ASSERT_NEXT(a_result_shown, clock, reset, cmd.emit || cmd.flush, rsp_tvalid, "issued result not presented")
   `SQB_ASSERT_NEXT(a_flush_last, clock, reset, cmd.flush, rsp_tlast, "end-of-scene result without last")

endmodule
